FILE: rtl/hart_frame_encoder_defines.svh
// Assertion macros used by the encoder back end, hfe_back.
// Each macro expects clk and rst_n in scope.
`ifndef HART_FRAME_ENCODER_DEFINES_SVH
`define HART_FRAME_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define HFE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HFE_ASSERT_NOW(lbl, ante, cons)
`define HFE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/hfe_pkg.sv
package hfe_pkg;

  localparam int PREAMBLE_LIMIT = 23;
  localparam int PRE_W          = $clog2(PREAMBLE_LIMIT + 1);
  localparam int BODY_MAX       = 10;
  localparam int IDX_W          = $clog2(BODY_MAX + 1);
  localparam int FIFO_DEPTH     = 2;
  localparam int FIFO_PW        = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW        = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 40;

  localparam logic [CFG_AW-1:0] REG_RESP_PRE  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_REQ_PRE   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_UNIQUE_ID = 3'd2;
  localparam logic [CFG_AW-1:0] REG_POLL_ADDR = 3'd3;
  localparam logic [CFG_AW-1:0] REG_STAT_PRI  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_STAT_SEC  = 3'd5;

  localparam logic       MODE_HEADER  = 1'b0;
  localparam logic       MODE_PAYLOAD = 1'b1;
  localparam logic [1:0] FT_RESPONSE  = 2'd1;
  localparam logic [1:0] FT_BURST     = 2'd2;

  localparam logic [7:0] DELIM_REQUEST  = 8'h02;
  localparam logic [7:0] DELIM_RESPONSE = 8'h06;
  localparam logic [7:0] DELIM_BURST    = 8'h01;
  localparam logic [7:0] LONG_FLAG      = 8'h80;
  localparam logic [7:0] MASTER_FLAG    = 8'h80;
  localparam logic [7:0] BURST_FLAG     = 8'h40;
  localparam logic [7:0] ADDR_MASK      = 8'h3f;
  localparam logic [7:0] COLD_START_BIT = 8'h10;
  localparam logic [7:0] PREAMBLE_BYTE  = 8'hff;
  localparam logic [7:0] CMD_GLOBAL_A   = 8'd11;
  localparam logic [7:0] CMD_GLOBAL_B   = 8'd21;

  typedef struct packed {
    logic                     restart;
    logic                     close;
    logic [PRE_W-1:0]         pre;
    logic [IDX_W-1:0]         len;
    logic [BODY_MAX-1:0][7:0] body;
  } hfe_entry_t;

endpackage

FILE: rtl/hfe_in_if.sv
interface hfe_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [1:0] frame_type;
  logic       long_addr;
  logic       primary_master;
  logic [7:0] command;
  logic [7:0] response_code;
  logic [7:0] data_len;
  logic [7:0] payload_byte;

  modport source (
    output valid, mode, frame_type, long_addr, primary_master, command,
           response_code, data_len, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, frame_type, long_addr, primary_master, command,
           response_code, data_len, payload_byte,
    output ready
  );
endinterface

FILE: rtl/hfe_out_if.sv
interface hfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       item_last;

  modport source (output valid, out_byte, frame_end, item_last, input ready);
  modport sink (input valid, out_byte, frame_end, item_last, output ready);
endinterface

FILE: rtl/hfe_front.sv
module hfe_front (
  input  logic                      clk,
  input  logic                      rst_n,
  hfe_in_if.sink                    in_if,
  input  logic                      cfg_we,
  input  logic [hfe_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [hfe_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                      q_full,
  output logic                      q_push,
  output hfe_pkg::hfe_entry_t       q_entry
);
  import hfe_pkg::*;

  logic [7:0]  resp_pre_r;
  logic [7:0]  req_pre_r;
  logic [39:0] uid_r;
  logic [5:0]  poll_r;
  logic [7:0]  stat_p_r;
  logic [7:0]  stat_s_r;

  logic [7:0] rem_r, rem_nxt;
  logic       open_r, open_nxt;
  logic       cs_p_r, cs_p_nxt;
  logic       cs_s_r, cs_s_nxt;

  logic        accept;
  logic        resp, burst, rb, global_cmd;
  logic [7:0]  pre_sel, delim, flags, cnt, stat;
  logic [39:0] addr_id;
  logic [PRE_W-1:0] pre_sat;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_pre_r <= 8'd5;
      req_pre_r  <= 8'd5;
      uid_r      <= '0;
      poll_r     <= '0;
      stat_p_r   <= '0;
      stat_s_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RESP_PRE:  resp_pre_r <= cfg_wdata[7:0];
        REG_REQ_PRE:   req_pre_r  <= cfg_wdata[7:0];
        REG_UNIQUE_ID: uid_r      <= cfg_wdata[39:0];
        REG_POLL_ADDR: poll_r     <= cfg_wdata[5:0];
        REG_STAT_PRI:  stat_p_r   <= cfg_wdata[7:0];
        REG_STAT_SEC:  stat_s_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    resp       = (in_if.frame_type == FT_RESPONSE);
    burst      = (in_if.frame_type == FT_BURST);
    rb         = resp || burst;
    global_cmd = (in_if.command == CMD_GLOBAL_A) || (in_if.command == CMD_GLOBAL_B);
    pre_sel    = rb ? resp_pre_r : req_pre_r;
    pre_sat    = (pre_sel > 8'(PREAMBLE_LIMIT)) ? PRE_W'(PREAMBLE_LIMIT)
                                                  : pre_sel[PRE_W-1:0];
    delim      = resp ? DELIM_RESPONSE : (burst ? DELIM_BURST : DELIM_REQUEST);
    flags      = (in_if.primary_master ? MASTER_FLAG : 8'h00) |
                 (burst ? BURST_FLAG : 8'h00);
    cnt        = rb ? in_if.data_len + 8'd2 : in_if.data_len;
    if (in_if.primary_master) begin
      stat = (stat_p_r & ~COLD_START_BIT) | (cs_p_r ? COLD_START_BIT : 8'h00);
    end else begin
      stat = (stat_s_r & ~COLD_START_BIT) | (cs_s_r ? COLD_START_BIT : 8'h00);
    end
    addr_id = global_cmd ? 40'd0 : uid_r;

    q_entry  = '0;
    q_push   = 1'b0;
    rem_nxt  = rem_r;
    open_nxt = open_r;
    cs_p_nxt = cs_p_r;
    cs_s_nxt = cs_s_r;

    if (in_if.mode == MODE_PAYLOAD) begin
      q_entry.body[0] = in_if.payload_byte;
      q_entry.len     = IDX_W'(1);
      q_entry.close   = (rem_r == 8'd1);
      if (accept && open_r) begin
        q_push  = 1'b1;
        rem_nxt = rem_r - 8'd1;
        if (rem_r == 8'd1) begin
          open_nxt = 1'b0;
        end
      end
    end else begin
      q_entry.restart = 1'b1;
      q_entry.close   = (in_if.data_len == 8'd0);
      q_entry.pre     = pre_sat;
      if (in_if.long_addr) begin
        q_entry.body[0] = delim | LONG_FLAG;
        q_entry.body[1] = (addr_id[39:32] & ADDR_MASK) | flags;
        q_entry.body[2] = addr_id[31:24];
        q_entry.body[3] = addr_id[23:16];
        q_entry.body[4] = addr_id[15:8];
        q_entry.body[5] = addr_id[7:0];
        q_entry.body[6] = in_if.command;
        q_entry.body[7] = cnt;
        q_entry.body[8] = in_if.response_code;
        q_entry.body[9] = stat;
        q_entry.len     = rb ? IDX_W'(10) : IDX_W'(8);
      end else begin
        q_entry.body[0] = delim;
        q_entry.body[1] = ({2'b00, poll_r} & ADDR_MASK) | flags;
        q_entry.body[2] = in_if.command;
        q_entry.body[3] = cnt;
        q_entry.body[4] = in_if.response_code;
        q_entry.body[5] = stat;
        q_entry.len     = rb ? IDX_W'(6) : IDX_W'(4);
      end
      if (accept) begin
        q_push   = 1'b1;
        rem_nxt  = in_if.data_len;
        open_nxt = (in_if.data_len != 8'd0);
        if (resp && in_if.primary_master) begin
          cs_p_nxt = 1'b0;
        end
        if (resp && !in_if.primary_master) begin
          cs_s_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      open_r <= 1'b0;
      cs_p_r <= 1'b1;
      cs_s_r <= 1'b1;
    end else begin
      rem_r  <= rem_nxt;
      open_r <= open_nxt;
      cs_p_r <= cs_p_nxt;
      cs_s_r <= cs_s_nxt;
    end
  end
endmodule

FILE: rtl/hfe_fifo.sv
module hfe_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hfe_pkg::hfe_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output hfe_pkg::hfe_entry_t head
);
  import hfe_pkg::*;

  hfe_entry_t         mem_r [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full       = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end
endmodule

FILE: rtl/hfe_back.sv
`include "hart_frame_encoder_defines.svh"

module hfe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  hfe_pkg::hfe_entry_t head,
  output logic                pop,
  hfe_out_if.source           out_if
);
  import hfe_pkg::*;

  logic [PRE_W-1:0] pcnt_r, pcnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       chk_r, chk_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             frame_end_r, frame_end_nxt;
  logic             item_last_r, item_last_nxt;

  logic       advance, pre_phase, body_phase, last;
  logic [7:0] body_byte, chk_base;

  assign out_if.valid     = out_valid_r;
  assign out_if.out_byte  = out_byte_r;
  assign out_if.frame_end = frame_end_r;
  assign out_if.item_last = item_last_r;

  always_comb begin
    advance    = head_valid && (!out_valid_r || out_if.ready);
    pre_phase  = (pcnt_r < head.pre);
    body_phase = !pre_phase && (idx_r < head.len);
    body_byte  = head.body[idx_r];
    chk_base   = (head.restart && idx_r == '0) ? 8'h00 : chk_r;
    if (body_phase) begin
      last = (idx_r == head.len - 1'b1) && !head.close;
    end else begin
      last = !pre_phase;
    end
    pop = advance && last;

    pcnt_nxt      = pcnt_r;
    idx_nxt       = idx_r;
    chk_nxt       = chk_r;
    out_byte_nxt  = out_byte_r;
    frame_end_nxt = frame_end_r;
    item_last_nxt = item_last_r;
    out_valid_nxt = out_if.ready ? 1'b0 : out_valid_r;

    if (advance) begin
      out_valid_nxt = 1'b1;
      item_last_nxt = last;
      frame_end_nxt = !pre_phase && !body_phase;
      if (pre_phase) begin
        out_byte_nxt = PREAMBLE_BYTE;
        pcnt_nxt     = pcnt_r + 1'b1;
      end else if (body_phase) begin
        out_byte_nxt = body_byte;
        chk_nxt      = chk_base ^ body_byte;
        idx_nxt      = idx_r + 1'b1;
      end else begin
        out_byte_nxt = chk_r;
      end
      if (last) begin
        pcnt_nxt = '0;
        idx_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    frame_end_r <= frame_end_nxt;
    item_last_r <= item_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r      <= '0;
      idx_r       <= '0;
      chk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pcnt_r      <= pcnt_nxt;
      idx_r       <= idx_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `HFE_ASSERT_NOW(a_idle_counters, !head_valid, pcnt_r == '0 && idx_r == '0)
  `HFE_ASSERT_NOW(a_pre_bound, head_valid, pcnt_r <= head.pre)
  `HFE_ASSERT_NOW(a_idx_bound, head_valid, idx_r <= head.len)
  `HFE_ASSERT_NOW(a_end_is_last, out_valid_r && frame_end_r, item_last_r)
  `HFE_ASSERT_NEXT(a_pop_resets, pop, pcnt_r == '0 && idx_r == '0)
endmodule

FILE: rtl/hart_frame_encoder.sv
// Channel  Direction  Transaction
// in_if    sink       header item (frame fields) or one payload byte
// out_if   source     one frame octet with frame_end and item_last
// cfg_*    write      register index and data, one register per cycle
//
// A transaction is taken every cycle while the two-entry queue has room.
// The emitter sends one octet per cycle while out_if is ready: a payload byte is one octet,
// plus the checksum after the last one; a header takes preambles plus 4 to 10 octets, plus
// the checksum when no payload follows, and the queue fills behind it meanwhile.
// Reset is synchronous and active low; there is no clearing pass after reset.
// A stall on out_if holds the output register and backs up into the queue, and
// into in_if once the queue is full.
module hart_frame_encoder (
  input  logic                       clk,
  input  logic                       rst_n,
  hfe_in_if.sink                     in_if,
  hfe_out_if.source                  out_if,
  input  logic                       cfg_we,
  input  logic [hfe_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [hfe_pkg::CFG_DW-1:0] cfg_wdata
);
  import hfe_pkg::*;

  logic       q_full, q_push, q_pop, q_head_valid;
  hfe_entry_t q_entry, q_head;

  hfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  hfe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .pop       (q_pop),
    .full      (q_full),
    .head_valid(q_head_valid),
    .head      (q_head)
  );

  hfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_head_valid),
    .head      (q_head),
    .pop       (q_pop),
    .out_if    (out_if)
  );
endmodule
